>>> rtl/tte_pkg.sv
// Shared types and constants for the tap tempo estimator.
package tte_pkg;

   localparam int TIME_W     = 32;
   localparam int TIMEOUT_W  = 16;
   localparam int BPM_W      = 14;
   localparam int TAPS_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Dividend holds 600000*(n-1) plus half of a 32-bit span.
   localparam int DIV_W     = 33;
   localparam int DIV_CNT_W = 6;

   localparam int                    TENTHS_W          = 20;
   localparam logic [TENTHS_W-1:0]   TENTHS_PER_MIN_MS = 20'd600000;

   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST = 16'd3000;
   localparam logic [BPM_W-1:0]      MIN_BPM_RST = 14'd400;
   localparam logic [BPM_W-1:0]      MAX_BPM_RST = 14'd2400;

   localparam logic [CSR_IDX_W-1:0]  CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_MIN_BPM = 2'd1;
   localparam logic [CSR_IDX_W-1:0]  CSR_MAX_BPM = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_OLDEST,
      ST_SPAN,
      ST_NUM,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

>>> rtl/tap_tempo_estimator.sv
// Tap tempo estimator top level: tap window, sequencer, clamp and output register.
//
// Each request carries one tap timestamp in milliseconds. The block keeps the
// newest MAX_TAPS taps in a small ring memory, empties the window when the gap
// since the last tap exceeds timeout_ms, and for two or more taps returns the
// tempo in tenths of BPM, rounded and clamped to the min/max registers, with
// the number of taps used.
// A tap that leaves fewer than two taps in the window yields no response: the
// sequencer passes through ST_GAP and ST_OLDEST and returns to idle. Otherwise
// it steps through ST_GAP, ST_OLDEST, ST_SPAN, ST_NUM, ST_DIV and ST_DONE before
// the response register loads; a zero span skips the 33-step restoring divider.
// The path holds one ring read each for the last and the oldest tap.
// A new tap is not taken before the sequencer is through with the last one;
// req_ready is high only when the sequencer is idle.
// A finished response sits in an output register; the next tap is accepted
// while it waits. If rsp_ready stays low, the following result holds the
// sequencer until the register frees.
// Reset empties the window and loads timeout 3000 ms, limits 40.0 and 240.0 BPM.
// Register writes are always accepted and must be made while no tap is pending.
module tap_tempo_estimator
   import tte_pkg::*;
#(
   parameter int MAX_TAPS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_W-1:0]     req_tap_time_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BPM_W-1:0]      rsp_bpm_tenths,
   output logic [TAPS_W-1:0]     rsp_taps_used,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W  = $clog2(MAX_TAPS);
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int EXT_W  = CNT_W + 1;
   localparam int PROD_W = TENTHS_W + CNT_W;

   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(MAX_TAPS - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TAPS);
   localparam logic [CNT_W-1:0] MIN_COUNT  = CNT_W'(2);
   localparam logic [EXT_W-1:0] RING_SIZE  = EXT_W'(MAX_TAPS);

   state_type            state_ff, state_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIME_W-1:0]    span_ff, span_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [BPM_W-1:0]     min_bpm_ff;
   logic [BPM_W-1:0]     max_bpm_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BPM_W-1:0]     bpm_ff;
   logic [TAPS_W-1:0]    taps_ff;
   logic                 rsp_load;

   logic [TIME_W-1:0]    ring [MAX_TAPS];
   logic [TIME_W-1:0]    rd_data_ff;
   logic                 rd_en;
   logic [PTR_W-1:0]     rd_addr;
   logic                 wr_en;

   logic [PTR_W-1:0]     prev_slot;
   logic [PTR_W-1:0]     next_slot;
   logic [EXT_W-1:0]     head_ext;
   logic [EXT_W-1:0]     cnt_ext;
   logic [EXT_W-1:0]     oldest_ext;
   logic [PTR_W-1:0]     oldest_slot;
   logic [TIME_W-1:0]    gap;
   logic                 restart;
   logic [CNT_W-1:0]     base_count;
   logic [PROD_W-1:0]    num;
   logic [DIV_W-1:0]     dividend;
   logic [BPM_W-1:0]     capped;
   logic [BPM_W-1:0]     bpm_clamped;

   logic                 div_start;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;

   assign prev_slot = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign next_slot = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   // oldest tap sits count slots behind the head, modulo the ring size
   assign head_ext    = EXT_W'(head_ff);
   assign cnt_ext     = EXT_W'(count_ff);
   assign oldest_ext  = (head_ext >= cnt_ext) ? head_ext - cnt_ext
                                              : head_ext + RING_SIZE - cnt_ext;
   assign oldest_slot = oldest_ext[PTR_W-1:0];

   assign gap        = now_ff - rd_data_ff;
   assign restart    = (count_ff != '0) && (gap > TIME_W'(timeout_ff));
   assign base_count = restart ? '0 : count_ff;

   // round half up: add half the span before dividing
   assign num      = PROD_W'(TENTHS_PER_MIN_MS) * PROD_W'(count_ff - 1'b1);
   assign dividend = DIV_W'(num) + DIV_W'(span_ff[TIME_W-1:1]);

   // lower to max first, then raise to min
   assign capped      = (quo_ff > DIV_W'(max_bpm_ff)) ? max_bpm_ff : quo_ff[BPM_W-1:0];
   assign bpm_clamped = (capped < min_bpm_ff) ? min_bpm_ff : capped;

   always_comb begin
      state_in  = state_ff;
      now_in    = now_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      span_in   = span_ff;
      quo_in    = quo_ff;
      rd_en     = 1'b0;
      rd_addr   = prev_slot;
      wr_en     = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               now_in   = req_tap_time_ms;
               rd_en    = 1'b1;
               rd_addr  = prev_slot;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            wr_en    = 1'b1;
            head_in  = next_slot;
            count_in = (base_count < FULL_COUNT) ? base_count + 1'b1 : base_count;
            state_in = ST_OLDEST;
         end
         ST_OLDEST: begin
            rd_en    = 1'b1;
            rd_addr  = oldest_slot;
            state_in = (count_ff < MIN_COUNT) ? ST_IDLE : ST_SPAN;
         end
         ST_SPAN: begin
            span_in  = now_ff - rd_data_ff;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            if (span_ff == '0) begin
               // zero span means unbounded tempo: take the upper limit
               quo_in   = DIV_W'(max_bpm_ff);
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               quo_in   = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
      if (rsp_load) begin
         bpm_ff  <= bpm_clamped;
         taps_ff <= TAPS_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[head_ff] <= now_ff;
      end
      if (rd_en) begin
         rd_data_ff <= ring[rd_addr];
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         min_bpm_ff <= MIN_BPM_RST;
         max_bpm_ff <= MAX_BPM_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata;
         end
         if (csr_index == CSR_MIN_BPM) begin
            min_bpm_ff <= csr_wdata[BPM_W-1:0];
         end
         if (csr_index == CSR_MAX_BPM) begin
            max_bpm_ff <= csr_wdata[BPM_W-1:0];
         end
      end
   end

   tte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bpm_tenths = bpm_ff;
   assign rsp_taps_used  = taps_ff;

endmodule

>>> rtl/tte_div.sv
// Restoring divider, one quotient bit per cycle.
module tte_div
   import tte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [TIME_W:0]      shifted;
   logic [TIME_W:0]      diff;
   logic                 fits;

   // remainder stays below the divisor, so its top bit after the shift fits in TIME_W+1
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
